// File: rtl/pae_kernel_page_table_engine_macros.svh
// Assertion macros shared by the page table engine checkers.
`ifndef PAE_KERNEL_PAGE_TABLE_ENGINE_MACROS_SVH
`define PAE_KERNEL_PAGE_TABLE_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, muted while reset is asserted.
`define PAE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("page table engine check failed");

// Next-cycle implication, sampled on clk, muted while reset is asserted.
`define PAE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("page table engine check failed");

`endif

// File: rtl/pae_pkg.sv
// Shared types, constants and codes of the kernel page table engine.
package pae_pkg;

	localparam int ENTRIES_PER_TABLE = 512;
	localparam int DIRECT_TABLES     = 128;
	localparam int DYNAMIC_TABLES    = 126;
	localparam int TOTAL_ENTRIES     = (DIRECT_TABLES + DYNAMIC_TABLES) * ENTRIES_PER_TABLE;
	localparam int DIRECT_ENTRIES    = DIRECT_TABLES * ENTRIES_PER_TABLE;

	localparam int POS_W = $clog2(TOTAL_ENTRIES);
	localparam int DYN_W = (DYNAMIC_TABLES > 1) ? $clog2(DYNAMIC_TABLES) : 1;
	localparam int CNT_W = 10;

	localparam logic [1:0]  KQUARTER  = 2'd3;
	localparam logic [31:0] KBASE     = 32'hC000_0000;
	localparam logic [31:0] DYN_BASE  = 32'hF000_0000;
	localparam int DYN_FIRST_DIR      = int'((DYN_BASE - KBASE) >> 21);

	// Flag bit positions shared by directory and page entries
	localparam int FB_P = 0;
	localparam int FB_W = 1;
	localparam int FB_U = 2;

	localparam logic [2:0]  DIR_PW = 3'b011;
	localparam logic [2:0]  DIR_UW = 3'b110;
	localparam logic [31:0] PTE_P  = 32'h0000_0001;
	localparam logic [31:0] PTE_W  = 32'h0000_0002;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	typedef enum logic [1:0] {
		CMD_MAP       = 2'd0,
		CMD_UNMAP     = 2'd1,
		CMD_TRANSLATE = 2'd2,
		CMD_PROTECT   = 2'd3
	} pae_cmd_e;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_MISALIGNED = 2'd1,
		ST_OUTSIDE    = 2'd2,
		ST_NOT_MAPPED = 2'd3
	} pae_status_e;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_READ,
		S_EXEC
	} pae_state_e;

	typedef struct packed {
		logic [2:0]       flags;
		logic [CNT_W-1:0] count;
	} pae_dir_t;

	typedef struct packed {
		pae_cmd_e         cmd;
		logic             done;
		pae_status_e      early_status;
		logic             is_dyn;
		logic [DYN_W-1:0] dyn_idx;
		logic [POS_W-1:0] pos;
		logic [11:0]      low;
		logic [19:0]      frame;
		logic [11:0]      flags;
	} pae_item_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} pae_ctl_t;

endpackage

// File: rtl/pae_kernel_page_table_engine.sv
// Top level of the kernel quarter page table engine.
//
// Input channel: in_valid / in_stall with cmd, virt_addr, phys_addr and map_flags.
// A transfer happens on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with status, phys_out and entry_flags,
// one result per command, in command order.
//
// Commands that need the tables go through the back end states S_READ, which reads the
// directory word and the page entry from synchronous RAM, and S_EXEC, which forms the
// result and writes back. Because of that RAM read-then-write sequence the back end
// takes no new command while a table command is in S_EXEC. Commands rejected by the
// front end classifier (misaligned, outside the window, no backing table) are answered
// straight from S_READ.
//
// After reset a clearing pass writes the reset image into the page entry RAM,
// one entry per cycle for all TOTAL_ENTRIES entries (130048 with the defaults), while
// in_stall stays high. A stalled result holds in the output register; the
// two-entry queue keeps taking commands until it fills, then in_stall rises.
module pae_kernel_page_table_engine import pae_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] virt_addr,
	input  logic [31:0] phys_addr,
	input  logic [11:0] map_flags,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] phys_out,
	output logic [11:0] entry_flags
);

	// Queue head and back end handshake
	pae_ctl_t  ctl;
	logic      q_valid;
	pae_item_t q_item;

	// Classify and queue incoming transfers
	pae_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.virt_addr (virt_addr),
		.phys_addr (phys_addr),
		.map_flags (map_flags),
		.ctl       (ctl),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	// Execute against the tables and drive results
	pae_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.ctl         (ctl),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.phys_out    (phys_out),
		.entry_flags (entry_flags)
	);

endmodule

// File: rtl/pae_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pae_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/pae_front.sv
// Front end: accept commands, classify them and hold them in a short queue.
module pae_front import pae_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] virt_addr,
	input  logic [31:0] phys_addr,
	input  logic [11:0] map_flags,
	input  pae_ctl_t    ctl,
	output logic        q_valid,
	output pae_item_t   q_item
);

	pae_item_t         item;
	pae_item_t         entries_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push;

	logic [1:0] q;
	logic [8:0] d;
	logic [8:0] t;
	logic [8:0] d_off;
	logic [8:0] slot;
	logic       is_direct;
	logic       in_dyn_dir;
	logic       backed;
	logic       window;
	logic       misaligned;

	assign q          = virt_addr[31:30];
	assign d          = virt_addr[29:21];
	assign t          = virt_addr[20:12];
	assign d_off      = d - 9'(DYN_FIRST_DIR);
	assign is_direct  = {1'b0, d} < 10'(DIRECT_TABLES);
	assign in_dyn_dir = (d >= 9'(DYN_FIRST_DIR)) && ({1'b0, d_off} < 10'(DYNAMIC_TABLES));
	assign backed     = is_direct || in_dyn_dir;
	assign window     = (virt_addr >= DYN_BASE) && in_dyn_dir;
	assign misaligned = (virt_addr[11:0] != 12'd0) || (phys_addr[11:0] != 12'd0);
	assign slot       = is_direct ? d : (9'(DIRECT_TABLES) + d_off);

	always_comb begin
		item              = '0;
		item.cmd          = pae_cmd_e'(cmd);
		item.is_dyn       = !is_direct && in_dyn_dir;
		item.dyn_idx      = d_off[DYN_W-1:0];
		item.pos          = POS_W'({slot, t});
		item.low          = virt_addr[11:0];
		item.frame        = phys_addr[31:12];
		item.flags        = map_flags;
		item.early_status = ST_NOT_MAPPED;
		unique case (pae_cmd_e'(cmd))
			CMD_MAP: begin
				if (misaligned) begin
					item.done         = 1'b1;
					item.early_status = ST_MISALIGNED;
				end else if (!window) begin
					item.done         = 1'b1;
					item.early_status = ST_OUTSIDE;
				end
			end
			CMD_UNMAP: begin
				if (!window) begin
					item.done         = 1'b1;
					item.early_status = ST_OUTSIDE;
				end
			end
			CMD_TRANSLATE, CMD_PROTECT: begin
				item.done = (q != KQUARTER) || !backed;
			end
			default: item.done = 1'b1;
		endcase
	end

	// Hold off new transfers while the tables are cleared or the queue is full
	assign in_stall = ctl.clearing || (cnt_q == (QPTR_W + 1)'(QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = cnt_q != '0;
	assign q_item   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (ctl.pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(ctl.pop);
		end
	end

endmodule

// File: rtl/pae_back.sv
// Back end: table memories, clearing pass, command execution and result register.
module pae_back import pae_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  pae_item_t   q_item,
	output pae_ctl_t    ctl,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] phys_out,
	output logic [11:0] entry_flags
);

	pae_state_e       state_q, state_d;
	logic [POS_W-1:0] clr_q;
	logic             clr_last;
	pae_item_t        item_q;
	logic             latch;

	logic             pg_we, pg_re;
	logic [POS_W-1:0] pg_waddr;
	logic [31:0]      pg_wdata, pg_rd;
	logic             dir_we;
	logic [DYN_W-1:0] dir_waddr;
	pae_dir_t         dir_wdata, dir_rd;

	logic             out_free, out_load;
	logic             out_valid_q;
	pae_status_e      status_q, res_status;
	logic [31:0]      phys_q, res_phys;
	logic [11:0]      eflags_q, res_eflags;

	logic             hit;

	assign clr_last = clr_q == POS_W'(TOTAL_ENTRIES - 1);
	assign out_free = !out_valid_q || !out_stall;
	assign hit      = (item_q.is_dyn ? dir_rd.flags[FB_P] : 1'b1) && pg_rd[FB_P];

	assign pg_waddr  = (state_q == S_CLEAR) ? clr_q : item_q.pos;
	assign dir_waddr = (state_q == S_CLEAR) ? clr_q[DYN_W-1:0] : item_q.dyn_idx;

	pae_ram #(.WIDTH(32), .DEPTH(TOTAL_ENTRIES)) u_page_ram (
		.clk     (clk),
		.wr_en   (pg_we),
		.wr_addr (pg_waddr),
		.wr_data (pg_wdata),
		.rd_en   (pg_re),
		.rd_addr (q_item.pos),
		.rd_data (pg_rd)
	);

	pae_ram #(.WIDTH($bits(pae_dir_t)), .DEPTH(DYNAMIC_TABLES)) u_dir_ram (
		.clk     (clk),
		.wr_en   (dir_we),
		.wr_addr (dir_waddr),
		.wr_data (dir_wdata),
		.rd_en   (pg_re),
		.rd_addr (q_item.dyn_idx),
		.rd_data (dir_rd)
	);

	always_comb begin
		state_d    = state_q;
		latch      = 1'b0;
		pg_re      = 1'b0;
		pg_we      = 1'b0;
		pg_wdata   = '0;
		dir_we     = 1'b0;
		dir_wdata  = dir_rd;
		out_load   = 1'b0;
		res_status = ST_NOT_MAPPED;
		res_phys   = '0;
		res_eflags = '0;
		ctl.pop      = 1'b0;
		ctl.clearing = state_q == S_CLEAR;
		unique case (state_q)
			S_CLEAR: begin
				pg_we     = 1'b1;
				pg_wdata  = (clr_q < POS_W'(DIRECT_ENTRIES)) ?
					32'({clr_q, 12'(DIR_PW)}) : 32'd0;
				dir_we    = clr_q < POS_W'(DYNAMIC_TABLES);
				dir_wdata = '0;
				if (clr_last) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (q_valid) begin
					if (q_item.done) begin
						if (out_free) begin
							out_load   = 1'b1;
							ctl.pop    = 1'b1;
							res_status = q_item.early_status;
						end
					end else begin
						pg_re   = 1'b1;
						ctl.pop = 1'b1;
						latch   = 1'b1;
						state_d = S_EXEC;
					end
				end
			end
			S_EXEC: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_READ;
					unique case (item_q.cmd)
						CMD_MAP: begin
							if (!dir_rd.flags[FB_P]) begin
								dir_wdata.flags = DIR_PW | {item_q.flags[FB_U], 2'b00};
								dir_wdata.count = '0;
							end else if (item_q.flags[FB_U] && !dir_rd.flags[FB_U]) begin
								dir_wdata.flags = dir_rd.flags | DIR_UW;
							end
							if (!pg_rd[FB_P]) begin
								dir_wdata.count = dir_wdata.count + 1'b1;
							end
							dir_we     = 1'b1;
							pg_we      = 1'b1;
							pg_wdata   = {item_q.frame, item_q.flags | PTE_P[11:0]};
							res_status = ST_OK;
						end
						CMD_UNMAP: begin
							if (hit) begin
								pg_we    = 1'b1;
								pg_wdata = '0;
								if (dir_rd.count != '0) begin
									dir_wdata.count = dir_rd.count - 1'b1;
								end
								// Drop the directory entry once its table is empty
								if (dir_wdata.count == '0) begin
									dir_wdata.flags = '0;
								end
								dir_we     = 1'b1;
								res_status = ST_OK;
							end
						end
						CMD_TRANSLATE: begin
							if (hit) begin
								res_phys   = {pg_rd[31:12], item_q.low};
								res_eflags = pg_rd[11:0];
								res_status = ST_OK;
							end
						end
						CMD_PROTECT: begin
							if (hit) begin
								pg_we      = 1'b1;
								pg_wdata   = pg_rd & ~PTE_W;
								res_status = ST_OK;
							end
						end
						default: res_status = ST_NOT_MAPPED;
					endcase
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_load || (out_valid_q && out_stall);
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (latch) begin
			item_q <= q_item;
		end
		if (out_load) begin
			status_q <= res_status;
			phys_q   <= res_phys;
			eflags_q <= res_eflags;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign phys_out    = phys_q;
	assign entry_flags = eflags_q;

endmodule

// File: rtl/pae_checker.sv
// Port-level checker of the page table engine and its bind.
`include "pae_kernel_page_table_engine_macros.svh"

module pae_checker import pae_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [31:0] phys_out,
	input logic [11:0] entry_flags
);

	// Commands taken but not yet answered
	logic [2:0] pending_q;
	logic       in_x, out_x;

	assign in_x  = in_valid && !in_stall;
	assign out_x = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_x) - 3'(out_x);
		end
	end

	`PAE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(phys_out) && $stable(entry_flags))
	`PAE_ASSERT_IMPL(a_fail_zero, out_valid && status != ST_OK, phys_out == 32'd0 && entry_flags == 12'd0)
	`PAE_ASSERT_IMPL(a_flags_present, out_valid && entry_flags != 12'd0, status == ST_OK && entry_flags[0])
	`PAE_ASSERT_IMPL(a_no_orphan, out_valid, pending_q != 3'd0)

endmodule

bind pae_kernel_page_table_engine pae_checker u_pae_checker (.*);

// File: dv/pae_kernel_page_table_engine_test.sv
// Self-checking testbench for the kernel quarter page table engine.
`timescale 1ns / 1ps

import pae_pkg::*;

// Shadow copy of the page hierarchy plus the queue of walk results it predicts
class page_table_shadow;
	typedef struct packed {
		pae_status_e status;
		logic [31:0] phys;
		logic [11:0] flags;
	} walk_result_t;

	logic [2:0]       dir_flags [512];
	logic [31:0]      page_entries [];
	logic [CNT_W-1:0] present_count [];
	walk_result_t     expected_walks [$];
	int               mismatches;
	int               results_seen;
	int               cmd_seen [4];
	int               status_seen [4];

	function new();
		page_entries  = new[TOTAL_ENTRIES];
		present_count = new[DYNAMIC_TABLES];
		foreach (dir_flags[d])
			dir_flags[d] = (d < DIRECT_TABLES) ? DIR_PW : 3'b000;
		foreach (page_entries[n])
			page_entries[n] = (n < DIRECT_ENTRIES) ? ((32'(n) << 12) | PTE_P | PTE_W) : 32'h0;
		foreach (present_count[k])
			present_count[k] = '0;
		mismatches   = 0;
		results_seen = 0;
		foreach (cmd_seen[k])
			cmd_seen[k] = 0;
		foreach (status_seen[k])
			status_seen[k] = 0;
	endfunction

	function int table_slot(logic [8:0] d);
		if (int'(d) < DIRECT_TABLES)
			return int'(d);
		if (int'(d) >= DYN_FIRST_DIR && int'(d) < DYN_FIRST_DIR + DYNAMIC_TABLES)
			return DIRECT_TABLES + int'(d) - DYN_FIRST_DIR;
		return -1;
	endfunction

	function int outstanding();
		return expected_walks.size();
	endfunction

	// Apply one accepted command to the shadow and queue the result it must produce
	function void predict_walk(pae_cmd_e op, logic [31:0] va, logic [31:0] pa,
			logic [11:0] fl);
		logic [1:0]   q;
		logic [8:0]   d;
		logic [8:0]   t;
		logic [2:0]   df;
		int           slot;
		int           pos;
		int           dyn;
		bit           in_win;
		bit           walk_ok;
		walk_result_t r;

		q    = va[31:30];
		d    = va[29:21];
		t    = va[20:12];
		slot = table_slot(d);
		pos  = (slot >= 0) ? slot * ENTRIES_PER_TABLE + int'(t) : 0;
		dyn  = (slot >= DIRECT_TABLES) ? slot - DIRECT_TABLES : 0;
		in_win = va >= DYN_BASE &&
			64'(va) < 64'(DYN_BASE) + 64'(DYNAMIC_TABLES) * 64'h20_0000;
		walk_ok = slot >= 0 && dir_flags[d][FB_P] && page_entries[pos][FB_P];
		r.status = ST_NOT_MAPPED;
		r.phys   = '0;
		r.flags  = '0;
		cmd_seen[op]++;

		case (op)
			CMD_MAP: begin
				if (va[11:0] != 12'h0 || pa[11:0] != 12'h0) begin
					r.status = ST_MISALIGNED;
				end else if (!in_win || slot < DIRECT_TABLES) begin
					r.status = ST_OUTSIDE;
				end else begin
					df = dir_flags[d];
					// An absent directory entry always has an all-zero table behind it
					if (!df[FB_P]) begin
						dir_flags[d] = DIR_PW | {fl[FB_U], 2'b00};
						present_count[dyn] = '0;
					end else if (fl[FB_U] && !df[FB_U]) begin
						dir_flags[d] = df | DIR_UW;
					end
					if (!page_entries[pos][FB_P])
						present_count[dyn] = present_count[dyn] + 1'b1;
					page_entries[pos] = {pa[31:12], fl} | PTE_P;
					r.status = ST_OK;
				end
			end
			CMD_UNMAP: begin
				// No alignment check on unmap
				if (!in_win || slot < DIRECT_TABLES) begin
					r.status = ST_OUTSIDE;
				end else if (dir_flags[d][FB_P] && page_entries[pos][FB_P]) begin
					page_entries[pos] = '0;
					if (present_count[dyn] != '0)
						present_count[dyn] = present_count[dyn] - 1'b1;
					// Drop the directory entry with its last page
					if (present_count[dyn] == '0)
						dir_flags[d] = '0;
					r.status = ST_OK;
				end
			end
			CMD_TRANSLATE: begin
				// Only the kernel quarter is present and backed by tables
				if (q == KQUARTER && walk_ok) begin
					r.phys   = {page_entries[pos][31:12], va[11:0]};
					r.flags  = page_entries[pos][11:0];
					r.status = ST_OK;
				end
			end
			default: begin
				if (q == KQUARTER && walk_ok) begin
					page_entries[pos] = page_entries[pos] & ~PTE_W;
					r.status = ST_OK;
				end
			end
		endcase
		expected_walks.push_back(r);
	endfunction

	task report_mismatch(string what);
		mismatches++;
		$display("[%0t] ERROR: %s", $realtime, what);
	endtask

	task check_result(logic [1:0] st, logic [31:0] ph, logic [11:0] ef);
		walk_result_t exp_r;
		if (expected_walks.size() == 0) begin
			report_mismatch($sformatf("result with nothing outstanding: status %0d phys %h flags %h",
				st, ph, ef));
			return;
		end
		exp_r = expected_walks.pop_front();
		results_seen++;
		status_seen[exp_r.status]++;
		if (st !== exp_r.status)
			report_mismatch($sformatf("result %0d status %0d, expected %0d",
				results_seen, st, exp_r.status));
		if (ph !== exp_r.phys)
			report_mismatch($sformatf("result %0d phys_out %h, expected %h",
				results_seen, ph, exp_r.phys));
		if (ef !== exp_r.flags)
			report_mismatch($sformatf("result %0d entry_flags %h, expected %h",
				results_seen, ef, exp_r.flags));
	endtask
endclass

module pae_kernel_page_table_engine_test;

	// The post-reset clearing pass keeps in_stall high while it clears every entry, so
	// the watchdog limit on cycles with no transfer is scaled from TOTAL_ENTRIES.
	localparam int QUIET_LIMIT  = 3 * TOTAL_ENTRIES + 10000;
	localparam int HOLD_CYCLES  = 64;
	localparam int DRAIN_CYCLES = 16;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd         = CMD_MAP;
	logic [31:0] virt_addr   = '0;
	logic [31:0] phys_addr   = '0;
	logic [11:0] map_flags   = '0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [1:0]  status;
	logic [31:0] phys_out;
	logic [11:0] entry_flags;

	page_table_shadow shadow;

	int send_idle_pct = 0;
	int out_stall_pct = 0;
	int hold_token    = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	pae_kernel_page_table_engine u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.virt_addr   (virt_addr),
		.phys_addr   (phys_addr),
		.map_flags   (map_flags),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.phys_out    (phys_out),
		.entry_flags (entry_flags)
	);

	always #1 clk = ~clk;

	// Result side: check every transfer against the oldest prediction, then pick
	// the next cycle's stall. A hold-off request forces a run of stalls set by HOLD_CYCLES.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			shadow.check_result(status, phys_out, entry_flags);
		if (hold_seen != hold_token) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < out_stall_pct);
		end
	end

	// Watchdog: count cycles in which neither channel makes a transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[%0t] watchdog: no transfer for %0d cycles, %0d results outstanding",
					$realtime, quiet_cycles, shadow.outstanding());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Offer one command after a random gap; return at the edge of its transfer.
	// Leave in_valid high so the next call can follow without a bubble.
	task automatic send_command(pae_cmd_e op, logic [31:0] va, logic [31:0] pa,
			logic [11:0] fl);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= op;
		virt_addr <= va;
		phys_addr <= pa;
		map_flags <= fl;
		do
			@(posedge clk);
		while (in_stall);
		shadow.predict_walk(op, va, pa, fl);
	endtask

	// Drop valid and hold until every predicted result has come back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (shadow.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_command();
		pae_cmd_e    op;
		logic [31:0] va;
		logic [31:0] pa;
		logic [11:0] fl;
		int          pick;
		int          d;
		int          pg;

		pick = $urandom_range(99);
		if (pick < 35)
			op = CMD_MAP;
		else if (pick < 65)
			op = CMD_UNMAP;
		else if (pick < 90)
			op = CMD_TRANSLATE;
		else
			op = CMD_PROTECT;

		pick = $urandom_range(99);
		if (pick < 60) begin
			// Hot set: first three dynamic tables and the last, mostly low pages,
			// so tables fill and empty again
			if ($urandom_range(3) == 3)
				d = DYN_FIRST_DIR + DYNAMIC_TABLES - 1;
			else
				d = DYN_FIRST_DIR + $urandom_range(2);
			pg = ($urandom_range(7) == 0) ? $urandom_range(ENTRIES_PER_TABLE - 1) :
				$urandom_range(7);
			va = {KQUARTER, 9'(d), 9'(pg), 12'h000};
			if ($urandom_range(3) == 0)
				va[11:0] = 12'($urandom);
		end else if (pick < 75) begin
			// Direct map
			va = {KQUARTER, 9'($urandom_range(DIRECT_TABLES - 1)), 21'($urandom)};
		end else if (pick < 85) begin
			// Kernel quarter directory entries with no table behind them
			if ($urandom_range(1) == 0)
				d = $urandom_range(DYN_FIRST_DIR - 1, DIRECT_TABLES);
			else
				d = $urandom_range(511, DYN_FIRST_DIR + DYNAMIC_TABLES);
			va = {KQUARTER, 9'(d), 21'($urandom)};
		end else if (pick < 90) begin
			// Window edges
			case ($urandom_range(4))
				0: va = DYN_BASE - 32'h1000;
				1: va = DYN_BASE;
				2: va = DYN_BASE + 32'(DYNAMIC_TABLES) * 32'h20_0000 - 32'h1000;
				3: va = DYN_BASE + 32'(DYNAMIC_TABLES) * 32'h20_0000;
				default: va = 32'hFFFF_F000;
			endcase
		end else begin
			va = $urandom;
		end

		pa = $urandom;
		if ($urandom_range(11) != 0)
			pa[11:0] = 12'h000;
		fl = 12'($urandom);
		send_command(op, va, pa, fl);
	endtask

	task automatic run_phase(int count, int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		out_stall_pct = stall_pct;
		repeat (count)
			send_random_command();
	endtask

	initial begin
		shadow = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed walk through the special cases, no idling
		send_command(CMD_MAP,       32'hF000_0000, 32'h1234_5000, 12'h000);
		send_command(CMD_TRANSLATE, 32'hF000_0ABC, 32'h0,         12'h0);
		// Map with user into a present non-user directory entry
		send_command(CMD_MAP,       32'hF000_1000, 32'hFFFF_F000, 12'hFFF);
		// Overwrite a present entry, count stays
		send_command(CMD_MAP,       32'hF000_0000, 32'h0000_1000, 12'h002);
		send_command(CMD_MAP,       32'hF000_2004, 32'h0000_2000, 12'h000);
		send_command(CMD_MAP,       32'hF000_2000, 32'h0000_0FFF, 12'h000);
		send_command(CMD_MAP,       32'hC000_0000, 32'h0000_3000, 12'h000);
		send_command(CMD_MAP,       32'hFFC0_0000, 32'h0000_4000, 12'h000);
		// Last dynamic page, absent directory entry created with user
		send_command(CMD_MAP,       32'hFFBF_F000, 32'hABCD_E000, 12'h004);
		send_command(CMD_MAP,       32'h0000_0000, 32'h0000_5000, 12'h000);
		send_command(CMD_TRANSLATE, 32'hC000_0123, 32'h0,         12'h0);
		send_command(CMD_TRANSLATE, 32'hCFFF_FFFF, 32'h0,         12'h0);
		send_command(CMD_TRANSLATE, 32'h4000_0000, 32'h0,         12'h0);
		send_command(CMD_TRANSLATE, 32'hE000_0000, 32'h0,         12'h0);
		send_command(CMD_TRANSLATE, 32'hFFE0_0000, 32'h0,         12'h0);
		send_command(CMD_PROTECT,   32'hC000_1000, 32'h0,         12'h0);
		send_command(CMD_TRANSLATE, 32'hC000_1000, 32'h0,         12'h0);
		send_command(CMD_PROTECT,   32'hF000_1000, 32'h0,         12'h0);
		send_command(CMD_TRANSLATE, 32'hF000_1FFF, 32'h0,         12'h0);
		send_command(CMD_PROTECT,   32'h0000_1000, 32'h0,         12'h0);
		// Unmap ignores the offset bits
		send_command(CMD_UNMAP,     32'hF000_0ABC, 32'h0,         12'h0);
		send_command(CMD_UNMAP,     32'hF000_0000, 32'h0,         12'h0);
		// Last present page of the table: directory entry goes away
		send_command(CMD_UNMAP,     32'hF000_1000, 32'h0,         12'h0);
		send_command(CMD_TRANSLATE, 32'hF000_1000, 32'h0,         12'h0);
		send_command(CMD_UNMAP,     32'hC000_0000, 32'h0,         12'h0);
		send_command(CMD_UNMAP,     32'hF040_0000, 32'h0,         12'h0);
		send_command(CMD_MAP,       32'hF000_1000, 32'h0007_7000, 12'h0F0);

		// Pause the sender until everything has drained
		wait_for_results();

		run_phase(180, 0, 0);
		run_phase(180, 77, 0);
		run_phase(180, 0, 77);
		run_phase(150, 13, 13);

		// Hold the result side off while commands keep coming, so the engine
		// fills up and raises in_stall
		hold_token++;
		run_phase(30, 0, 0);

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d commands (%0d map, %0d unmap, %0d translate, %0d protect)",
			shadow.cmd_seen[CMD_MAP] + shadow.cmd_seen[CMD_UNMAP] +
			shadow.cmd_seen[CMD_TRANSLATE] + shadow.cmd_seen[CMD_PROTECT],
			shadow.cmd_seen[CMD_MAP], shadow.cmd_seen[CMD_UNMAP],
			shadow.cmd_seen[CMD_TRANSLATE], shadow.cmd_seen[CMD_PROTECT]);
		$display("under mixed idle and stall; %0d results: %0d ok, %0d misaligned, %0d outside, %0d not mapped",
			shadow.results_seen, shadow.status_seen[ST_OK], shadow.status_seen[ST_MISALIGNED],
			shadow.status_seen[ST_OUTSIDE], shadow.status_seen[ST_NOT_MAPPED]);
		if (shadow.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
